### hdl/tlfc_pkg.sv
// Shared types, constants and helpers for the text layout feature counter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package tlfc_pkg;

    // Counter and fixed point sizing
    localparam int COUNT_BITS  = 24;
    localparam int FRAC_BITS   = 16;
    localparam int BAL_W       = COUNT_BITS + 1;
    localparam int Q1_W        = FRAC_BITS + 1;
    localparam int Q8_W        = FRAC_BITS + 8;
    localparam int DIV_W       = COUNT_BITS + FRAC_BITS;
    localparam int STEP_W      = $clog2(DIV_W + 1);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LBRACE = 8'h7B;

    typedef logic [COUNT_BITS-1:0]    cnt_t;
    typedef logic signed [BAL_W-1:0]  bal_t;
    typedef logic [DIV_W-1:0]         quo_t;
    typedef logic [Q1_W-1:0]          q1_t;
    typedef logic [Q8_W-1:0]          q8_t;

    localparam cnt_t CNT_MAX = {COUNT_BITS{1'b1}};
    localparam bal_t BAL_MAX = {1'b0, {COUNT_BITS{1'b1}}};
    localparam bal_t BAL_MIN = {1'b1, {COUNT_BITS{1'b0}}};
    localparam quo_t Q1_CAP  = quo_t'(1) << FRAC_BITS;
    localparam quo_t Q8_CAP  = (quo_t'(1) << Q8_W) - quo_t'(1);

    // Totals of one finished text, handed from front to back
    typedef struct packed {
        cnt_t byte_total;
        cnt_t tab_total;
        cnt_t space_total;
        cnt_t blank_total;
        cnt_t empty_line_total;
        logic brace_pos;
        logic tabs_lead;
        logic overflow;
    } snap_t;

    // Division jobs of the back end, in order
    typedef enum logic [1:0] {
        OP_TAB   = 2'd0,
        OP_SPACE = 2'd1,
        OP_EMPTY = 2'd2,
        OP_BLANK = 2'd3
    } div_op_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOAD,
        BK_DIV,
        BK_STORE,
        BK_OUT
    } back_state_t;

    // Saturating increment
    function automatic cnt_t cnt_inc(input cnt_t c);
        return (c == CNT_MAX) ? c : c + cnt_t'(1);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
    endfunction

endpackage

### hdl/tlfc_stream_if.sv
// Valid/ready channel interfaces for the byte stream and the result stream.
// Depends on tlfc_pkg for field widths.
`timescale 1ns / 1ps

interface tlfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last_byte;

    modport source (output valid, output char_in, output last_byte, input ready);
    modport sink   (input valid, input char_in, input last_byte, output ready);
endinterface

interface tlfc_result_if;
    import tlfc_pkg::*;

    logic valid;
    logic ready;
    q1_t  tab_ratio;
    q1_t  space_ratio;
    q1_t  empty_line_ratio;
    q8_t  whitespace_ratio;
    logic brace_own_line;
    logic tabs_lead;
    logic all_whitespace;
    logic count_overflow;

    modport source (output valid, output tab_ratio, output space_ratio,
                    output empty_line_ratio, output whitespace_ratio,
                    output brace_own_line, output tabs_lead, output all_whitespace,
                    output count_overflow, input ready);
    modport sink   (input valid, input tab_ratio, input space_ratio,
                    input empty_line_ratio, input whitespace_ratio,
                    input brace_own_line, input tabs_lead, input all_whitespace,
                    input count_overflow, output ready);
endinterface

### hdl/tlfc_front.sv
// Front end: takes one byte per transfer, updates the layout counters and,
// on the final byte, pushes the totals into the queue. Depends on tlfc_pkg.
`timescale 1ns / 1ps

module tlfc_front (
    input  logic                clk,
    input  logic                rst_n,
    tlfc_byte_if.sink           byte_stream,
    input  logic                q_full,
    output logic                q_push,
    output tlfc_pkg::snap_t     q_snap
);
    import tlfc_pkg::*;

    logic prev_newline_reg, prev_newline_next;
    logic line_empty_reg, line_empty_next;
    cnt_t byte_reg, byte_next;
    cnt_t tab_reg, tab_next;
    cnt_t space_reg, space_next;
    cnt_t blank_reg, blank_next;
    cnt_t empty_reg, empty_next;
    bal_t bal_reg, bal_next;
    cnt_t tlead_reg, tlead_next;
    cnt_t slead_reg, slead_next;
    logic ovf_reg, ovf_next;

    logic       take;
    logic [7:0] c;
    logic       ws;
    logic       is_tab, is_space, is_lf, is_cr;

    assign byte_stream.ready = ~q_full;
    assign take     = byte_stream.valid & ~q_full;
    assign c        = byte_stream.char_in;
    assign ws       = is_blank(c);
    assign is_tab   = (c == CH_TAB);
    assign is_space = (c == CH_SPACE);
    assign is_lf    = (c == CH_LF);
    assign is_cr    = (c == CH_CR);

    // Count one byte
    always_comb
    begin
        prev_newline_next = prev_newline_reg;
        line_empty_next   = line_empty_reg;
        byte_next         = byte_reg;
        tab_next          = tab_reg;
        space_next        = space_reg;
        blank_next        = blank_reg;
        empty_next        = empty_reg;
        bal_next          = bal_reg;
        tlead_next        = tlead_reg;
        slead_next        = slead_reg;
        ovf_next          = ovf_reg;

        if (take)
        begin
            byte_next = cnt_inc(byte_reg);
            if (byte_reg == CNT_MAX)
                ovf_next = 1'b1;

            if (ws)
            begin
                blank_next = cnt_inc(blank_reg);
                if (blank_reg == CNT_MAX)
                    ovf_next = 1'b1;
                if (is_tab)
                begin
                    tab_next = cnt_inc(tab_reg);
                    if (tab_reg == CNT_MAX)
                        ovf_next = 1'b1;
                end
                if (is_space)
                begin
                    space_next = cnt_inc(space_reg);
                    if (space_reg == CNT_MAX)
                        ovf_next = 1'b1;
                end
                if (is_lf)
                    line_empty_next = 1'b1;
            end
            else
            begin
                if (c == CH_LBRACE)
                begin
                    if (line_empty_reg)
                    begin
                        if (bal_reg == BAL_MAX)
                            ovf_next = 1'b1;
                        else
                            bal_next = bal_reg + bal_t'(1);
                    end
                    else
                    begin
                        if (bal_reg == BAL_MIN)
                            ovf_next = 1'b1;
                        else
                            bal_next = bal_reg - bal_t'(1);
                    end
                end
                line_empty_next = 1'b0;
            end

            // Classify the first byte after each line feed
            if (prev_newline_reg)
            begin
                if (is_lf || is_cr)
                begin
                    empty_next = cnt_inc(empty_reg);
                    if (empty_reg == CNT_MAX)
                        ovf_next = 1'b1;
                end
                else if (is_tab)
                begin
                    tlead_next = cnt_inc(tlead_reg);
                    if (tlead_reg == CNT_MAX)
                        ovf_next = 1'b1;
                end
                else if (is_space)
                begin
                    slead_next = cnt_inc(slead_reg);
                    if (slead_reg == CNT_MAX)
                        ovf_next = 1'b1;
                end
            end
            prev_newline_next = is_lf;
        end
    end

    // Hand the totals of a finished text to the back end
    assign q_push = take & byte_stream.last_byte;
    always_comb
    begin
        q_snap.byte_total       = byte_next;
        q_snap.tab_total        = tab_next;
        q_snap.space_total      = space_next;
        q_snap.blank_total      = blank_next;
        q_snap.empty_line_total = empty_next;
        q_snap.brace_pos        = (bal_next > bal_t'(0));
        q_snap.tabs_lead        = (tlead_next > slead_next);
        q_snap.overflow         = ovf_next;
    end

    // Hold counters; clear them after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_newline_reg <= 1'b0;
            line_empty_reg   <= 1'b1;
            byte_reg         <= '0;
            tab_reg          <= '0;
            space_reg        <= '0;
            blank_reg        <= '0;
            empty_reg        <= '0;
            bal_reg          <= '0;
            tlead_reg        <= '0;
            slead_reg        <= '0;
            ovf_reg          <= 1'b0;
        end
        else if (q_push)
        begin
            prev_newline_reg <= 1'b0;
            line_empty_reg   <= 1'b1;
            byte_reg         <= '0;
            tab_reg          <= '0;
            space_reg        <= '0;
            blank_reg        <= '0;
            empty_reg        <= '0;
            bal_reg          <= '0;
            tlead_reg        <= '0;
            slead_reg        <= '0;
            ovf_reg          <= 1'b0;
        end
        else
        begin
            prev_newline_reg <= prev_newline_next;
            line_empty_reg   <= line_empty_next;
            byte_reg         <= byte_next;
            tab_reg          <= tab_next;
            space_reg        <= space_next;
            blank_reg        <= blank_next;
            empty_reg        <= empty_next;
            bal_reg          <= bal_next;
            tlead_reg        <= tlead_next;
            slead_reg        <= slead_next;
            ovf_reg          <= ovf_next;
        end
    end

endmodule

### hdl/tlfc_queue.sv
// Short queue of finished-text totals between front and back ends.
// Depends on tlfc_pkg for the entry type and depth.
`timescale 1ns / 1ps

module tlfc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tlfc_pkg::snap_t     push_data,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output tlfc_pkg::snap_t     pop_data
);
    import tlfc_pkg::*;

    snap_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push & ~full;
    assign do_pop    = pop & not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Occupancy never exceeds the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    // A push is never offered to a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

endmodule

### hdl/tlfc_back.sv
// Back end: pops text totals and works out the four ratios with one
// restoring divider, one quotient bit per cycle. Depends on tlfc_pkg.
`timescale 1ns / 1ps

module tlfc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  tlfc_pkg::snap_t     q_snap,
    output logic                q_pop,
    tlfc_result_if.source       result
);
    import tlfc_pkg::*;

    back_state_t        state_reg, state_next;
    div_op_t            op_reg, op_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    snap_t              snap_reg;
    quo_t               quo_reg;
    cnt_t               rem_reg;
    cnt_t               dsr_reg;
    q1_t                tab_r_reg, space_r_reg, empty_r_reg;
    q8_t                ws_r_reg;
    logic               all_ws_reg;

    cnt_t               nonws;
    cnt_t               numer;
    logic [COUNT_BITS:0] rem_shift;
    logic               ge;
    q1_t                q1_sat;
    q8_t                q8_sat;

    assign nonws = snap_reg.byte_total - snap_reg.blank_total;

    // Select numerator per job
    always_comb
    begin
        unique case (op_reg)
            OP_TAB:   numer = snap_reg.tab_total;
            OP_SPACE: numer = snap_reg.space_total;
            OP_EMPTY: numer = snap_reg.empty_line_total;
            OP_BLANK: numer = snap_reg.blank_total;
            default:  numer = snap_reg.tab_total;
        endcase
    end

    // One restoring division step
    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign ge        = (rem_shift >= {1'b0, dsr_reg});

    // Clamp the quotient to its output range
    assign q1_sat = (quo_reg > Q1_CAP) ? Q1_CAP[Q1_W-1:0] : quo_reg[Q1_W-1:0];
    assign q8_sat = (quo_reg > Q8_CAP) ? Q8_CAP[Q8_W-1:0] : quo_reg[Q8_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        step_next  = step_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    op_next    = OP_TAB;
                    state_next = BK_LOAD;
                end
            end
            BK_LOAD:
            begin
                step_next = '0;
                if (op_reg == OP_BLANK && nonws == '0)
                    state_next = BK_OUT;
                else
                    state_next = BK_DIV;
            end
            BK_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_W - 1))
                    state_next = BK_STORE;
            end
            BK_STORE:
            begin
                unique case (op_reg)
                    OP_TAB:   op_next = OP_SPACE;
                    OP_SPACE: op_next = OP_EMPTY;
                    OP_EMPTY: op_next = OP_BLANK;
                    OP_BLANK: op_next = OP_BLANK;
                    default:  op_next = OP_TAB;
                endcase
                state_next = (op_reg == OP_BLANK) ? BK_OUT : BK_LOAD;
            end
            BK_OUT:
            begin
                if (result.ready)
                    state_next = BK_IDLE;
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            op_reg    <= OP_TAB;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            step_reg  <= step_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            snap_reg   <= q_snap;
            all_ws_reg <= 1'b0;
        end
        if (state_reg == BK_LOAD)
        begin
            quo_reg <= {numer, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            dsr_reg <= (op_reg == OP_BLANK) ? nonws : snap_reg.byte_total;
            if (op_reg == OP_BLANK && nonws == '0)
            begin
                ws_r_reg   <= Q8_CAP[Q8_W-1:0];
                all_ws_reg <= 1'b1;
            end
        end
        if (state_reg == BK_DIV)
        begin
            rem_reg <= ge ? cnt_t'(rem_shift - {1'b0, dsr_reg}) : rem_shift[COUNT_BITS-1:0];
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
        end
        if (state_reg == BK_STORE)
        begin
            case (op_reg)
                OP_TAB:   tab_r_reg   <= q1_sat;
                OP_SPACE: space_r_reg <= q1_sat;
                OP_EMPTY: empty_r_reg <= q1_sat;
                default:  ws_r_reg    <= q8_sat;
            endcase
        end
    end

    // Drive the result channel
    assign result.valid            = (state_reg == BK_OUT);
    assign result.tab_ratio        = tab_r_reg;
    assign result.space_ratio      = space_r_reg;
    assign result.empty_line_ratio = empty_r_reg;
    assign result.whitespace_ratio = ws_r_reg;
    assign result.brace_own_line   = snap_reg.brace_pos;
    assign result.tabs_lead        = snap_reg.tabs_lead;
    assign result.all_whitespace   = all_ws_reg;
    assign result.count_overflow   = snap_reg.overflow;

    // Step counter stays inside the division length
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_DIV |-> step_reg < STEP_W'(DIV_W))
        else $error("divider step count out of range");

    // A result appears only after the last job or the all-blank shortcut
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(op_reg == OP_BLANK))
        else $error("result raised before the last division");

    // All-blank text reports a saturated whitespace ratio
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.all_whitespace |-> result.whitespace_ratio == Q8_CAP[Q8_W-1:0])
        else $error("all-blank text without saturated ratio");

    // The queue is popped only while the back end is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == BK_IDLE && q_valid)
        else $error("queue popped while busy");

endmodule

### hdl/text_layout_feature_counter.sv
// Top level of the text layout feature counter: front end, queue, back end.
// Depends on tlfc_pkg, tlfc_stream_if, tlfc_front, tlfc_queue and tlfc_back.
`timescale 1ns / 1ps

// The block takes one text byte per cycle on byte_stream and counts its layout
// features as it goes; nothing comes out until a transfer with last_byte set.
// That final byte closes the text: its totals move into a two-entry queue and
// the counters clear, so the next text can start on the following cycle. A
// single restoring divider in the back end turns the totals into the four
// ratios, one quotient bit per cycle; the whitespace division is skipped when
// the text holds no non-whitespace byte. The byte input stalls only when two
// finished texts already wait in the queue while the divider is still busy
// or a result is not taken.
module text_layout_feature_counter (
    input  logic            clk,
    input  logic            rst_n,
    tlfc_byte_if.sink       byte_stream,
    tlfc_result_if.source   result
);
    import tlfc_pkg::*;

    logic   q_full;
    logic   q_push;
    snap_t  q_push_data;
    logic   q_pop;
    logic   q_not_empty;
    snap_t  q_pop_data;

    // Count bytes
    tlfc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_snap      (q_push_data)
    );

    // Buffer finished texts
    tlfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    // Divide and report
    tlfc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_not_empty),
        .q_snap  (q_pop_data),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

### tb/tb_text_layout_feature_counter.sv
// Self-checking testbench for text_layout_feature_counter.
// Depends on tlfc_pkg, the tlfc_stream_if channel interfaces and the RTL top level.
`timescale 1ns / 1ps

module tb_text_layout_feature_counter;
    import tlfc_pkg::*;

    localparam int HOLD_CYCLES = 2000;
    localparam int TAIL_CYCLES = 200;
    localparam int MAX_PRINTS  = 40;

    typedef struct {
        q1_t  tab_ratio;
        q1_t  space_ratio;
        q1_t  empty_line_ratio;
        q8_t  whitespace_ratio;
        logic brace_own_line;
        logic tabs_lead;
        logic all_whitespace;
        logic count_overflow;
    } layout_result_t;

    logic clk;
    logic rst_n;

    tlfc_byte_if   byte_ch ();
    tlfc_result_if res_ch ();

    text_layout_feature_counter uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_ch),
        .result      (res_ch)
    );

    // Predicted layout of the text in progress
    logic   after_lf;
    logic   line_blank;
    cnt_t   n_bytes;
    cnt_t   n_tabs;
    cnt_t   n_spaces;
    cnt_t   n_white;
    cnt_t   n_empty_lines;
    cnt_t   n_tab_led;
    cnt_t   n_space_led;
    bal_t   brace_bal;
    logic   sat_seen;

    layout_result_t pending_layouts[$];
    logic [7:0]     text_buf[$];

    int   tx_idle_pct;
    int   rx_idle_pct;
    logic rx_hold = 1'b0;
    event hold_start;

    int n_errors;
    int n_results;
    int n_texts;
    int n_bytes_sent;

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Give up after a generous fixed time
    initial
    begin
        #20_000_000;
        $display("Timeout with %0d layouts still pending", pending_layouts.size());
        $display("simulation failed");
        $finish;
    end

    // Drive result ready: random stalls, or a long hold when requested
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Count out the long receiver hold
    initial
    begin
        forever
        begin
            @(hold_start);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                      n_results, name, got, want));
    endtask

    // Saturating count; flag the text when a counter sticks at its limit
    task automatic bump(inout cnt_t v);
        if (v == CNT_MAX)
            sat_seen = 1'b1;
        else
            v = v + cnt_t'(1);
    endtask

    // floor(num * 2^FRAC_BITS / den), clipped at cap
    function automatic logic [63:0] fixed_ratio(input logic [63:0] num,
                                                input logic [63:0] den,
                                                input logic [63:0] cap);
        logic [63:0] q;
        q = (num << FRAC_BITS) / den;
        return (q > cap) ? cap : q;
    endfunction

    task automatic clear_layout();
        after_lf      = 1'b0;
        line_blank    = 1'b1;
        n_bytes       = '0;
        n_tabs        = '0;
        n_spaces      = '0;
        n_white       = '0;
        n_empty_lines = '0;
        n_tab_led     = '0;
        n_space_led   = '0;
        brace_bal     = '0;
        sat_seen      = 1'b0;
    endtask

    // Advance the layout prediction by one byte; queue the result on the last one
    task automatic count_text_byte(input logic [7:0] c, input logic last);
        logic           ws;
        cnt_t           nonws;
        layout_result_t r;
        case (c)
            CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF: ws = 1'b1;
            default: ws = 1'b0;
        endcase
        bump(n_bytes);
        if (ws)
        begin
            if (c == CH_TAB)
                bump(n_tabs);
            if (c == CH_SPACE)
                bump(n_spaces);
            if (c == CH_LF)
                line_blank = 1'b1;
            bump(n_white);
        end
        else
        begin
            if (c == CH_LBRACE)
            begin
                if (line_blank)
                begin
                    if (brace_bal == BAL_MAX)
                        sat_seen = 1'b1;
                    else
                        brace_bal = brace_bal + bal_t'(1);
                end
                else
                begin
                    if (brace_bal == BAL_MIN)
                        sat_seen = 1'b1;
                    else
                        brace_bal = brace_bal - bal_t'(1);
                end
            end
            line_blank = 1'b0;
        end
        if (after_lf)
        begin
            if (c == CH_LF || c == CH_CR)
                bump(n_empty_lines);
            else if (c == CH_TAB)
                bump(n_tab_led);
            else if (c == CH_SPACE)
                bump(n_space_led);
        end
        after_lf = (c == CH_LF);

        if (last)
        begin
            nonws = n_bytes - n_white;
            r.tab_ratio        = q1_t'(fixed_ratio(64'(n_tabs), 64'(n_bytes), 64'(Q1_CAP)));
            r.space_ratio      = q1_t'(fixed_ratio(64'(n_spaces), 64'(n_bytes), 64'(Q1_CAP)));
            r.empty_line_ratio = q1_t'(fixed_ratio(64'(n_empty_lines), 64'(n_bytes),
                                                   64'(Q1_CAP)));
            if (nonws == '0)
                r.whitespace_ratio = q8_t'(Q8_CAP);
            else
                r.whitespace_ratio = q8_t'(fixed_ratio(64'(n_white), 64'(nonws),
                                                       64'(Q8_CAP)));
            r.brace_own_line = (brace_bal > 0);
            r.tabs_lead      = (n_tab_led > n_space_led);
            r.all_whitespace = (nonws == '0);
            r.count_overflow = sat_seen;
            pending_layouts.push_back(r);
            clear_layout();
        end
    endtask

    // Check each result transfer, then predict from each byte transfer
    always @(posedge clk)
    begin : check_results
        layout_result_t want;
        if (res_ch.valid && res_ch.ready)
        begin
            if (pending_layouts.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with none expected",
                                          n_results));
            end
            else
            begin
                want = pending_layouts.pop_front();
                compare_field("tab_ratio", res_ch.tab_ratio, want.tab_ratio);
                compare_field("space_ratio", res_ch.space_ratio, want.space_ratio);
                compare_field("empty_line_ratio", res_ch.empty_line_ratio,
                              want.empty_line_ratio);
                compare_field("whitespace_ratio", res_ch.whitespace_ratio,
                              want.whitespace_ratio);
                compare_field("brace_own_line", res_ch.brace_own_line, want.brace_own_line);
                compare_field("tabs_lead", res_ch.tabs_lead, want.tabs_lead);
                compare_field("all_whitespace", res_ch.all_whitespace, want.all_whitespace);
                compare_field("count_overflow", res_ch.count_overflow, want.count_overflow);
            end
            n_results++;
        end
        if (rst_n && byte_ch.valid && byte_ch.ready)
            count_text_byte(byte_ch.char_in, byte_ch.last_byte);
    end

    // Offer one byte, idling first at random; return at the edge of its transfer
    task automatic send_byte(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.char_in   <= c;
        byte_ch.last_byte <= last;
        do
            @(posedge clk);
        while (!(byte_ch.valid && byte_ch.ready));
    endtask

    task automatic send_text();
        int i;
        for (i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
        n_texts++;
        n_bytes_sent += text_buf.size();
        text_buf.delete();
    endtask

    task automatic add_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_CR;
            4:       return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] pick_code_char();
        case ($urandom_range(7))
            0:       return CH_SPACE;
            1:       return CH_LBRACE;
            2:       return 8'h7D;
            3:       return 8'h3B;
            default: return 8'h61 + 8'($urandom_range(25));
        endcase
    endfunction

    // Source-like lines: indentation, leading braces, empty lines
    task automatic build_code_text();
        int lines;
        int i;
        int indent;
        lines = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
        for (i = 0; i < lines; i++)
        begin
            case ($urandom_range(9))
                0: text_buf.push_back(CH_LF);
                1:
                begin
                    text_buf.push_back(CH_CR);
                    text_buf.push_back(CH_LF);
                end
                default:
                begin
                    indent = $urandom_range(3);
                    if (indent == 1)
                        repeat ($urandom_range(1, 3)) text_buf.push_back(CH_TAB);
                    else if (indent == 2)
                        repeat ($urandom_range(1, 8)) text_buf.push_back(CH_SPACE);
                    else if (indent == 3)
                        repeat ($urandom_range(1, 4))
                            text_buf.push_back($urandom_range(1) ? CH_TAB : CH_SPACE);
                    if ($urandom_range(3) == 0)
                        text_buf.push_back(CH_LBRACE);
                    repeat ($urandom_range(0, 6)) text_buf.push_back(pick_code_char());
                    if (i < lines - 1 || $urandom_range(1) == 1)
                        text_buf.push_back(CH_LF);
                end
            endcase
        end
        if (text_buf.size() == 0)
            text_buf.push_back(CH_LBRACE);
    endtask

    task automatic build_random_text();
        int kind;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            build_code_text();
        end
        else if (kind < 90)
        begin
            // Noise: any byte, or one of the characters the block cares about
            repeat ($urandom_range(1, 16))
            begin
                if ($urandom_range(1) == 1)
                    text_buf.push_back(8'($urandom_range(255)));
                else if ($urandom_range(6) == 0)
                    text_buf.push_back(CH_LBRACE);
                else
                    text_buf.push_back(pick_blank());
            end
        end
        else
        begin
            // Mostly whitespace, sometimes with a single visible byte
            repeat ($urandom_range(1, 20)) text_buf.push_back(pick_blank());
            if ($urandom_range(1) == 1)
                text_buf.push_back(8'h21 + 8'($urandom_range(93)));
        end
    endtask

    task automatic test_directed();
        tx_idle_pct = 22;
        rx_idle_pct = 86;
        // One-byte text
        add_str("A");
        send_text();
        // Every whitespace kind but LF, nothing else
        text_buf = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};
        send_text();
        // Empty lines by LF and CR, tab- and space-led lines, braces on and off line start
        text_buf = '{CH_LBRACE, CH_LF, CH_LF, CH_CR, CH_LF, CH_TAB, CH_LBRACE, CH_LF,
                     CH_SPACE, 8'h78, CH_LBRACE};
        send_text();
        // Zero byte and high bytes count as visible; tab-led line wins
        text_buf = '{8'h00, 8'hFF, 8'h80, CH_LF, CH_TAB};
        send_text();
        // Brace after text drives the balance negative
        text_buf = '{8'h61, CH_LBRACE};
        send_text();
    endtask

    task automatic test_random_phase(input int budget, input int tx_pct, input int rx_pct,
                                     input bit with_blank_run);
        int sent;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        sent = 0;
        if (with_blank_run)
        begin
            // Enough whitespace per visible byte to pin the whitespace ratio at its cap
            repeat ($urandom_range(256, 300)) text_buf.push_back(pick_blank());
            text_buf.push_back(8'h78);
            sent += text_buf.size();
            send_text();
        end
        while (sent < budget)
        begin
            build_random_text();
            sent += text_buf.size();
            send_text();
        end
    endtask

    // Hold results off while short texts keep coming, so the input stalls
    task automatic test_backpressure();
        int k;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        -> hold_start;
        for (k = 0; k < 12; k++)
        begin
            repeat ($urandom_range(1, 4))
                text_buf.push_back($urandom_range(1) ? pick_code_char() : pick_blank());
            send_text();
        end
    endtask

    initial
    begin
        n_errors     = 0;
        n_results    = 0;
        n_texts      = 0;
        n_bytes_sent = 0;
        tx_idle_pct  = 22;
        rx_idle_pct  = 86;
        clear_layout();
        rst_n             <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.char_in   <= 8'h00;
        byte_ch.last_byte <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(490, 22, 86, 1'b0);
        test_random_phase(490, 86, 22, 1'b0);
        test_random_phase(490, 0, 0, 1'b1);
        test_backpressure();
        byte_ch.valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (pending_layouts.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d texts (%0d bytes): directed layouts, code-like and noise text,",
                 n_texts, n_bytes_sent);
        $display("  three idling mixes and a %0d-cycle result hold; %0d results, %0d mismatches",
                 HOLD_CYCLES, n_results, n_errors);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
